@@ rtl/dss_pkg.sv @@
`timescale 1ns / 1ps
// Package for the dual stack block: sizes, codes, command and result types.
// No dependencies; imported by every module of the block.
package dss_pkg;

    localparam int DEPTH   = 16;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // mode field encodings
    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_POP  = 2'd1;
    localparam logic [1:0] MODE_DUMP = 2'd2;

    // status field encodings
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic SEL_LOWER = 1'b0;
    localparam logic SEL_UPPER = 1'b1;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_DUMP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              sel;
        logic [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
        logic [1:0]        status;
        logic              last;
    } result_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_POP_OUT,
        BK_DUMP
    } back_state_t;

endpackage

@@ rtl/dss_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts command transactions, decodes mode, drops unused codes.
// Depends on dss_pkg.
module dss_front
    import dss_pkg::*;
(
    input  logic              start,
    input  logic [1:0]        mode,
    input  logic              stack_select,
    input  logic [DATA_W-1:0] push_value,
    input  logic              queue_full,
    output logic              busy,
    output logic              queue_wr,
    output cmd_t              queue_cmd
);

    logic accept;
    logic known;

    assign busy   = queue_full;
    assign accept = start && !queue_full;

    always_comb
    begin
        known         = 1'b1;
        queue_cmd.op  = OP_PUSH;
        unique case (mode)
            MODE_PUSH: queue_cmd.op = OP_PUSH;
            MODE_POP:  queue_cmd.op = OP_POP;
            MODE_DUMP: queue_cmd.op = OP_DUMP;
            default:   known = 1'b0;  // unused code: no result, no change
        endcase
        queue_cmd.sel   = stack_select;
        queue_cmd.value = push_value;
    end

    assign queue_wr = accept && known;

endmodule

@@ rtl/dss_queue.sv @@
`timescale 1ns / 1ps
// Short command queue between front and back end.
// Depends on dss_pkg.
module dss_queue
    import dss_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr,
    input  cmd_t  wr_cmd,
    input  logic  rd,
    output cmd_t  rd_cmd,
    output logic  full,
    output logic  not_empty
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_cmd    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = rd ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(wr) - QCNT_W'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            entry_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

@@ rtl/dss_back.sv @@
`timescale 1ns / 1ps
// Back end: stack counts, shared memory and result sequencing.
// Depends on dss_pkg.
module dss_back
    import dss_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_take,
    output result_t result
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    back_state_t       state_reg,  state_next;
    logic [CNT_W-1:0]  lower_reg,  lower_next;
    logic [CNT_W-1:0]  upper_reg,  upper_next;
    logic [ADDR_W-1:0] ptr_reg,    ptr_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic              sel_reg,    sel_next;
    result_t           res_reg,    res_next;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              re;
    logic [ADDR_W-1:0] raddr;

    logic [CNT_W:0]    total;
    logic [CNT_W-1:0]  sel_cnt;
    logic [CNT_W-1:0]  depth_c;
    logic [ADDR_W-1:0] ptr_step;

    assign total    = {1'b0, lower_reg} + {1'b0, upper_reg};
    assign sel_cnt  = (cmd.sel == SEL_LOWER) ? lower_reg : upper_reg;
    assign depth_c  = CNT_W'(DEPTH);
    assign ptr_step = (sel_reg == SEL_LOWER) ? ptr_reg - 1'b1 : ptr_reg + 1'b1;
    assign result   = res_reg;

    always_comb
    begin
        state_next  = state_reg;
        lower_next  = lower_reg;
        upper_next  = upper_reg;
        ptr_next    = ptr_reg;
        remain_next = remain_reg;
        sel_next    = sel_reg;
        res_next    = '0;
        cmd_take    = 1'b0;
        we          = 1'b0;
        waddr       = '0;
        re          = 1'b0;
        raddr       = '0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take      = 1'b1;
                    res_next.last = 1'b1;
                    unique case (cmd.op)
                        OP_PUSH:
                        begin
                            res_next.valid = 1'b1;
                            if (total >= {1'b0, depth_c})
                                res_next.status = ST_FULL;
                            else if (cmd.sel == SEL_LOWER)
                            begin
                                we         = 1'b1;
                                waddr      = lower_reg[ADDR_W-1:0];
                                lower_next = lower_reg + 1'b1;
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = ADDR_W'(depth_c - upper_reg - 1'b1);
                                upper_next = upper_reg + 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            if (sel_cnt == '0)
                            begin
                                res_next.valid  = 1'b1;
                                res_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                re         = 1'b1;
                                state_next = BK_POP_OUT;
                                if (cmd.sel == SEL_LOWER)
                                begin
                                    raddr      = ADDR_W'(lower_reg - 1'b1);
                                    lower_next = lower_reg - 1'b1;
                                end
                                else
                                begin
                                    raddr      = ADDR_W'(depth_c - upper_reg);
                                    upper_next = upper_reg - 1'b1;
                                end
                            end
                        end
                        OP_DUMP:
                        begin
                            if (sel_cnt == '0)
                            begin
                                res_next.valid  = 1'b1;
                                res_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                // first read goes out now, data lands in BK_DUMP
                                if (cmd.sel == SEL_LOWER)
                                    raddr = ADDR_W'(sel_cnt - 1'b1);
                                else
                                    raddr = ADDR_W'(depth_c - sel_cnt);
                                re          = 1'b1;
                                ptr_next    = raddr;
                                remain_next = sel_cnt;
                                sel_next    = cmd.sel;
                                state_next  = BK_DUMP;
                            end
                        end
                        default:
                        begin
                            res_next = '0;
                        end
                    endcase
                end
            end
            BK_POP_OUT:
            begin
                res_next.valid = 1'b1;
                res_next.data  = rdata_reg;
                res_next.last  = 1'b1;
                state_next     = BK_IDLE;
            end
            BK_DUMP:
            begin
                res_next.valid = 1'b1;
                res_next.data  = rdata_reg;
                res_next.last  = (remain_reg == CNT_W'(1));
                remain_next    = remain_reg - 1'b1;
                if (remain_reg == CNT_W'(1))
                    state_next = BK_IDLE;
                else
                begin
                    re       = 1'b1;
                    raddr    = ptr_step;
                    ptr_next = ptr_step;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            lower_reg  <= '0;
            upper_reg  <= '0;
            remain_reg <= '0;
            res_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            lower_reg  <= lower_next;
            upper_reg  <= upper_next;
            remain_reg <= remain_next;
            res_reg    <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        sel_reg <= sel_next;
    end

    // shared stack memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= cmd.value;
        if (re)
            rdata_reg <= mem[raddr];
    end

endmodule

@@ rtl/dual_stack_shared_memory_top.sv @@
`timescale 1ns / 1ps
// Top level of the two-stacks-in-one-memory block.
// Depends on dss_pkg, dss_front, dss_queue, dss_back.
//
// Two stacks share one memory of DEPTH words: the lower stack grows up from
// address 0, the upper stack grows down from DEPTH-1. A command transaction is
// taken when start is high and busy is low. mode selects push, pop or dump of
// the stack picked by stack_select; mode three is taken and dropped silently.
// Every result appears for exactly one cycle with result_valid high; the
// receiver cannot stall, so results must be captured when shown. last marks
// the final result of a transaction. A push leaves the execution unit idle,
// so pushes stream at one per cycle while no pop or dump is in progress; a
// pop or a dump holds the execution unit until its last result, as the data
// passes through the registered read port of the shared memory. A push into
// a full memory gives status full, a pop or dump of an empty stack gives
// status empty, in both cases with data_value zero. A two entry command queue
// sits between the decoder and the execution unit; busy is high while it is
// full. With the execution unit idle, a taken transaction passes the queue
// and the result register, with the memory read register between them for
// a pop or dump with entries; queued commands or a dump in progress delay it.
module dual_stack_shared_memory_top
    import dss_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               mode,
    input  logic                     stack_select,
    input  logic signed [DATA_W-1:0] push_value,
    output logic                     result_valid,
    output logic signed [DATA_W-1:0] data_value,
    output logic [1:0]               status,
    output logic                     last
);

    logic    queue_wr;
    cmd_t    queue_in;
    logic    queue_full;
    logic    queue_rd;
    cmd_t    queue_out;
    logic    queue_not_empty;
    result_t result;

    // front end: decode and push into the queue
    dss_front u_front (
        .start        (start),
        .mode         (mode),
        .stack_select (stack_select),
        .push_value   (push_value),
        .queue_full   (queue_full),
        .busy         (busy),
        .queue_wr     (queue_wr),
        .queue_cmd    (queue_in)
    );

    dss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (queue_wr),
        .wr_cmd    (queue_in),
        .rd        (queue_rd),
        .rd_cmd    (queue_out),
        .full      (queue_full),
        .not_empty (queue_not_empty)
    );

    // back end: owns the counts and the shared memory
    dss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_not_empty),
        .cmd       (queue_out),
        .cmd_take  (queue_rd),
        .result    (result)
    );

    assign result_valid = result.valid;
    assign data_value   = result.data;
    assign status       = result.status;
    assign last         = result.last;

endmodule
